[hw/rtl/fba_pkg.sv]
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, types and codes for the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int NUM_FRAMES = 4096;
	localparam int MAP_WORDS  = (NUM_FRAMES + 31) / 32;
	localparam int WORD_AW    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CUR_W      = 12;
	localparam int LAST_BITS  = NUM_FRAMES - (MAP_WORDS - 1) * 32;

	// bits of the last map word that lie beyond the last frame read as used
	localparam logic [31:0] PAD_MASK  = (LAST_BITS == 32) ? 32'd0 :
		~((32'd1 << LAST_BITS) - 32'd1);
	localparam logic [WORD_AW-1:0] LAST_WORD = WORD_AW'(MAP_WORDS - 1);

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE   = 2'd0,
		ST_NOFREE = 2'd1,
		ST_SKIP   = 2'd2
	} status_t;

	typedef enum logic {
		FSM_IDLE = 1'b0,
		FSM_LOOK = 1'b1
	} fsm_t;

	// word write-back seen by the summary flags
	typedef struct packed {
		logic               en;
		logic [WORD_AW-1:0] addr;
		logic               full;
	} fba_upd_t;

endpackage

[hw/rtl/fba_ram.sv]
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hw/rtl/fba_summary.sv]
// ----------------------------------------------------------------------------
// fba_summary
// Per-word written and full flags of the used-bit map, and the search for
// the lowest map word that still has a clear bit.
// ----------------------------------------------------------------------------
module fba_summary
	import fba_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic [WORD_AW-1:0] look_addr,
	output logic               look_valid,
	output logic [WORD_AW-1:0] first_free,
	input  fba_upd_t           upd
);

	logic [MAP_WORDS-1:0] valid_q;
	logic [MAP_WORDS-1:0] full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			full_q  <= '0;
		end else if (upd.en) begin
			valid_q[upd.addr] <= 1'b1;
			full_q[upd.addr]  <= upd.full;
		end
	end

	assign look_valid = valid_q[look_addr];

	// lowest word not full; word zero when every word is full
	always_comb begin
		first_free = '0;
		for (int i = MAP_WORDS - 1; i >= 0; i--) begin
			if (!full_q[i]) begin
				first_free = WORD_AW'(i);
			end
		end
	end

endmodule

[hw/rtl/frame_bitmap_allocator.sv]
// ----------------------------------------------------------------------------
// frame_bitmap_allocator
// Used-bit map of physical page frames: allocates the lowest free frame and
// frees frames by index. Map words live in a RAM, per-word flags in flops.
// ----------------------------------------------------------------------------
// flow: the map word is read into the RAM read register, then modified, written
//   back and loaded into the output register; a held output stalls the write-back
//   and a new word is accepted only once the last has left the modify stage
// reset: per-word written and full flags clear at once, an unwritten map
//   word reads as all frames free; no clearing pass
module frame_bitmap_allocator
	import fba_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  logic [CUR_W-1:0] current_frame,
	input  logic             kernel_page,
	input  logic             rw_page,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [CUR_W-1:0] frame_number,
	output logic             present,
	output logic             writable,
	output logic             user_mode,
	output logic [1:0]       status
);

	fsm_t state_q, state_d;
	logic accept, advance;

	// request held through the lookup
	kind_t              kind_q;
	logic [CUR_W-1:0]   cur_q;
	logic               kern_q, wr_q;
	logic [WORD_AW-1:0] addr_s1;
	logic               rv_s1;

	logic [WORD_AW-1:0] look_addr, first_free;
	logic               look_valid;
	logic [31:0]        rdata, word, eff, new_word;
	logic [4:0]         bit_idx;
	logic               found, cur_in_range, do_write;
	fba_upd_t           upd;

	logic [CUR_W-1:0]   res_frame;
	logic               res_pres, res_rw, res_usr;
	status_t            res_st;

	logic               out_valid_q;

	// ---------------- control ----------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (in_valid) state_d = FSM_LOOK;
			end
			FSM_LOOK: begin
				if (!out_valid_q || out_ready) state_d = FSM_IDLE;
			end
			default: state_d = FSM_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		advance  = 1'b0;
		unique case (state_q)
			FSM_IDLE: in_ready = 1'b1;
			FSM_LOOK: advance  = !out_valid_q || out_ready;
			default: begin
				in_ready = 1'b0;
				advance  = 1'b0;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------- read stage ----------------
	assign look_addr = (kind_t'(kind) == KIND_FREE) ?
		WORD_AW'(current_frame[CUR_W-1:5]) : first_free;

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q  <= kind_t'(kind);
			cur_q   <= current_frame;
			kern_q  <= kernel_page;
			wr_q    <= rw_page;
			addr_s1 <= look_addr;
			rv_s1   <= look_valid;
		end
	end

	fba_summary u_summary (
		.clk        (clk),
		.arst_n     (arst_n),
		.look_addr  (look_addr),
		.look_valid (look_valid),
		.first_free (first_free),
		.upd        (upd)
	);

	fba_ram #(
		.WIDTH (32),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (do_write),
		.waddr (addr_s1),
		.wdata (new_word),
		.re    (accept),
		.raddr (look_addr),
		.rdata (rdata)
	);

	// ---------------- modify stage ----------------
	assign word = rv_s1 ? rdata : 32'd0;
	assign eff  = word | ((addr_s1 == LAST_WORD) ? PAD_MASK : 32'd0);

	// lowest clear bit of the word
	always_comb begin
		bit_idx = '0;
		found   = 1'b0;
		for (int b = 31; b >= 0; b--) begin
			if (!eff[b]) begin
				bit_idx = 5'(b);
				found   = 1'b1;
			end
		end
	end

	assign cur_in_range = 32'(cur_q) < 32'(NUM_FRAMES);

	always_comb begin
		res_frame = '0;
		res_pres  = 1'b0;
		res_rw    = 1'b0;
		res_usr   = 1'b0;
		res_st    = ST_DONE;
		new_word  = word;
		do_write  = 1'b0;
		unique case (kind_q)
			KIND_ALLOC: begin
				if (cur_q != '0) begin
					res_frame = cur_q;
					res_st    = ST_SKIP;
				end else if (found) begin
					new_word  = word | (32'd1 << bit_idx);
					do_write  = advance;
					res_frame = CUR_W'({addr_s1, bit_idx});
					res_pres  = 1'b1;
					res_rw    = wr_q;
					res_usr   = !kern_q;
				end else begin
					res_st = ST_NOFREE;
				end
			end
			KIND_FREE: begin
				if (cur_q == '0) begin
					res_st = ST_SKIP;
				end else if (cur_in_range) begin
					new_word = word & ~(32'd1 << cur_q[4:0]);
					do_write = advance;
				end
			end
			default: res_st = ST_SKIP;
		endcase
	end

	always_comb begin
		upd.en   = do_write;
		upd.addr = addr_s1;
		upd.full = (new_word | ((addr_s1 == LAST_WORD) ? PAD_MASK : 32'd0))
			== 32'hFFFF_FFFF;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			frame_number <= res_frame;
			present      <= res_pres;
			writable     <= res_rw;
			user_mode    <= res_usr;
			status       <= res_st;
		end
	end

	assign out_valid = out_valid_q;

endmodule
